// ===== sv/ncs_pkg.sv =====
// Shared types, constants and the default color table for the nearest palette color search.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package ncs_pkg;

	localparam int IDX_W = 8;      // palette index width on the ports
	localparam int CH_W = 8;       // width of one 8-bit color channel
	localparam int NIB_W = 4;      // stored bits per channel
	localparam int ENTRY_W = 3 * NIB_W;
	localparam int SQ_W = 2 * CH_W;
	localparam int DIST_W = SQ_W + 2;
	localparam int COUNT_W = 9;    // window length, zero through 511
	localparam int PALETTE_SIZE_DEF = 256;
	localparam int TABLE_DEPTH = 256;

	localparam logic [CH_W-1:0] WINDOW_START_RST = 8'h00;
	localparam logic [COUNT_W-1:0] WINDOW_COUNT_RST = 9'd256;

	typedef enum logic [0:0] {
		CFG_WINDOW_START = 1'b0,
		CFG_WINDOW_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		ACT_WRITE = 1'b0,
		ACT_SEARCH = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		action_t action;
		logic [IDX_W-1:0] entry_index;
		logic [CH_W-1:0] entry_red;
		logic [CH_W-1:0] entry_green;
		logic [CH_W-1:0] entry_blue;
		logic [CH_W-1:0] pixel_red;
		logic [CH_W-1:0] pixel_green;
		logic [CH_W-1:0] pixel_blue;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] nearest_index;
		logic is_search_answer;
	} result_t;

	// Registered read response of the palette store.
	typedef struct packed {
		logic valid;
		logic [IDX_W-1:0] addr;
		logic [ENTRY_W-1:0] entry;
	} pal_rd_t;

	// Registered output of the distance unit.
	typedef struct packed {
		logic valid;
		logic [IDX_W-1:0] idx;
		logic [DIST_W-1:0] sq_dist;
	} dist_resp_t;

	// Contents of the palette after reset, red in the top nibble.
	localparam logic [ENTRY_W-1:0] DEFAULT_PALETTE [TABLE_DEPTH] = '{
		12'h000, 12'hfff, 12'h800, 12'hafe, 12'hc4c, 12'h0c5, 12'h00a, 12'hee7,
		12'hd85, 12'h640, 12'hf77, 12'h333, 12'h777, 12'haf6, 12'h08f, 12'hbbb,
		12'h000, 12'h111, 12'h222, 12'h333, 12'h444, 12'h555, 12'h666, 12'h777,
		12'h888, 12'h999, 12'haaa, 12'hbbb, 12'hccc, 12'hddd, 12'heee, 12'hfff,
		12'h211, 12'h433, 12'h644, 12'h866, 12'ha88, 12'hc99, 12'hfbb, 12'h211,
		12'h422, 12'h633, 12'h844, 12'ha55, 12'hc66, 12'hf77, 12'h200, 12'h411,
		12'h611, 12'h822, 12'ha22, 12'hc33, 12'hf33, 12'h200, 12'h400, 12'h600,
		12'h800, 12'ha00, 12'hc00, 12'hf00, 12'h221, 12'h443, 12'h664, 12'h886,
		12'haa8, 12'hcc9, 12'hfeb, 12'h211, 12'h432, 12'h653, 12'h874, 12'ha95,
		12'hcb6, 12'hfd7, 12'h210, 12'h431, 12'h651, 12'h862, 12'ha82, 12'hca3,
		12'hfc3, 12'h210, 12'h430, 12'h640, 12'h860, 12'ha80, 12'hc90, 12'hfb0,
		12'h121, 12'h343, 12'h564, 12'h786, 12'h9a8, 12'hbc9, 12'hdfb, 12'h121,
		12'h342, 12'h463, 12'h684, 12'h8a5, 12'h9c6, 12'hbf7, 12'h120, 12'h241,
		12'h461, 12'h582, 12'h6a2, 12'h8c3, 12'h9f3, 12'h120, 12'h240, 12'h360,
		12'h480, 12'h5a0, 12'h6c0, 12'h7f0, 12'h121, 12'h343, 12'h465, 12'h686,
		12'h8a8, 12'h9ca, 12'hbfc, 12'h121, 12'h242, 12'h364, 12'h485, 12'h5a6,
		12'h6c8, 12'h7f9, 12'h020, 12'h141, 12'h162, 12'h283, 12'h2a4, 12'h3c5,
		12'h3f6, 12'h020, 12'h041, 12'h061, 12'h082, 12'h0a2, 12'h0c3, 12'h0f3,
		12'h122, 12'h344, 12'h466, 12'h688, 12'h8aa, 12'h9cc, 12'hbff, 12'h122,
		12'h244, 12'h366, 12'h488, 12'h5aa, 12'h6cc, 12'h7ff, 12'h022, 12'h144,
		12'h166, 12'h288, 12'h2aa, 12'h3cc, 12'h3ff, 12'h022, 12'h044, 12'h066,
		12'h088, 12'h0aa, 12'h0cc, 12'h0ff, 12'h112, 12'h334, 12'h456, 12'h668,
		12'h88a, 12'h9ac, 12'hbcf, 12'h112, 12'h224, 12'h346, 12'h458, 12'h56a,
		12'h68c, 12'h79f, 12'h002, 12'h114, 12'h126, 12'h238, 12'h24a, 12'h35c,
		12'h36f, 12'h002, 12'h014, 12'h016, 12'h028, 12'h02a, 12'h03c, 12'h03f,
		12'h112, 12'h334, 12'h546, 12'h768, 12'h98a, 12'hb9c, 12'hdbf, 12'h112,
		12'h324, 12'h436, 12'h648, 12'h85a, 12'h96c, 12'hb7f, 12'h102, 12'h214,
		12'h416, 12'h528, 12'h62a, 12'h83c, 12'h93f, 12'h102, 12'h204, 12'h306,
		12'h408, 12'h50a, 12'h60c, 12'h70f, 12'h212, 12'h434, 12'h646, 12'h868,
		12'ha8a, 12'hc9c, 12'hfbe, 12'h211, 12'h423, 12'h635, 12'h847, 12'ha59,
		12'hc6b, 12'hf7d, 12'h201, 12'h413, 12'h615, 12'h826, 12'ha28, 12'hc3a,
		12'hf3c, 12'h201, 12'h403, 12'h604, 12'h806, 12'ha08, 12'hc09, 12'hf0b
	};

endpackage

`default_nettype wire

// ===== sv/nearest_palette_color_search.sv =====
// Top level of the nearest palette color search: sequencer, configuration registers and
// result register. Depends on ncs_pkg, ncs_mod, ncs_palette and ncs_dist.
`default_nettype none

// The block keeps a palette of PALETTE_SIZE 12-bit colors (4 bits per channel) that holds
// the built-in default table after reset. Each item is either a write, which stores the
// upper nibbles of an RGB triple at entry_index modulo PALETTE_SIZE, or a search, which
// returns the index of the entry closest in squared Euclidean distance to an 8-bit RGB
// pixel, looking at window_count entries from window_start onward and wrapping at the end
// of the palette; among equal distances the one met first wins, and an empty window answers
// index zero. Every item gives exactly one result transfer. The block takes one item at a
// time: item_stall is high from the transfer of an item until its result has been placed in
// the output register, and the output register frees the input side again while that result
// waits for its own transfer. An item first reduces its index (entry_index or window_start)
// modulo the palette size by a reciprocal multiplication. A write then updates the palette
// and its result goes to the output register. A search reads the palette through its single
// read port at one entry a cycle, followed by the read, distance and compare stages, and its
// result goes to the output register once the scan and these stages are through. A finished
// result waits while a stalled receiver has not yet emptied the output register. Configuration
// writes are always taken (cfg_ready is high) and belong in idle periods only. There is no
// clearing pass after reset.
module nearest_palette_color_search #(
	parameter int PALETTE_SIZE = ncs_pkg::PALETTE_SIZE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire ncs_pkg::item_t item,
	output logic result_valid,
	input wire logic result_stall,
	output ncs_pkg::result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire ncs_pkg::cfg_reg_t cfg_index,
	input wire logic [ncs_pkg::COUNT_W-1:0] cfg_data
);

	localparam int AW = $clog2(PALETTE_SIZE);
	localparam int IW = ncs_pkg::IDX_W;
	localparam int NW = ncs_pkg::NIB_W;

	ncs_pkg::state_t state_q;
	ncs_pkg::state_t state_d;

	// Configuration registers.
	logic [IW-1:0] window_start_q;
	logic [ncs_pkg::COUNT_W-1:0] window_count_q;

	// The item being worked on.
	ncs_pkg::item_t item_q;

	// Scan state: next address to read, reads still to issue, best match so far.
	logic [AW-1:0] pos_q;
	logic [ncs_pkg::COUNT_W-1:0] issue_cnt_q;
	logic have_q;
	logic [IW-1:0] best_q;
	logic [ncs_pkg::DIST_W-1:0] best_d_q;

	ncs_pkg::result_t result_q;
	logic result_valid_q;

	logic accept;
	logic result_free;
	logic mod_start;
	logic [IW-1:0] mod_value;
	logic mod_done;
	logic [IW-1:0] mod_rem;
	logic pal_we;
	logic rd_en;
	logic scan_done;
	logic load_result;
	logic [ncs_pkg::ENTRY_W-1:0] wdata;
	ncs_pkg::pal_rd_t pal_rd;
	ncs_pkg::dist_resp_t dist_resp;

	assign accept = item_valid && !item_stall;
	// The output register can take a new result when empty or when its result leaves now.
	assign result_free = !result_valid_q || !result_stall;
	assign scan_done = (issue_cnt_q == '0) && !pal_rd.valid && !dist_resp.valid;
	assign wdata = {item_q.entry_red[ncs_pkg::CH_W-1 -: NW],
		item_q.entry_green[ncs_pkg::CH_W-1 -: NW],
		item_q.entry_blue[ncs_pkg::CH_W-1 -: NW]};

	ncs_mod #(
		.PALETTE_SIZE(PALETTE_SIZE)
	) u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(mod_start),
		.value(mod_value),
		.done(mod_done),
		.remainder(mod_rem)
	);

	ncs_palette #(
		.PALETTE_SIZE(PALETTE_SIZE)
	) u_palette (
		.clk(clk),
		.arst_n(arst_n),
		.we(pal_we),
		.waddr(mod_rem[AW-1:0]),
		.wdata(wdata),
		.re(rd_en),
		.raddr(pos_q),
		.rd(pal_rd)
	);

	ncs_dist u_dist (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_red(item_q.pixel_red),
		.pixel_green(item_q.pixel_green),
		.pixel_blue(item_q.pixel_blue),
		.rd(pal_rd),
		.resp(dist_resp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ncs_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = ncs_pkg::ST_MOD;
				end
			end
			ncs_pkg::ST_MOD: begin
				if (mod_done) begin
					state_d = (item_q.action == ncs_pkg::ACT_SEARCH) ? ncs_pkg::ST_SCAN
						: ncs_pkg::ST_RESULT;
				end
			end
			ncs_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = ncs_pkg::ST_RESULT;
				end
			end
			ncs_pkg::ST_RESULT: begin
				if (result_free) begin
					state_d = ncs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ncs_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		item_stall = (state_q != ncs_pkg::ST_IDLE);
		mod_start = accept;
		mod_value = (item.action == ncs_pkg::ACT_SEARCH) ? window_start_q : item.entry_index;
		pal_we = (state_q == ncs_pkg::ST_MOD) && mod_done
			&& (item_q.action == ncs_pkg::ACT_WRITE);
		rd_en = (state_q == ncs_pkg::ST_SCAN) && (issue_cnt_q != '0);
		load_result = (state_q == ncs_pkg::ST_RESULT) && result_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ncs_pkg::ST_IDLE;
			window_start_q <= ncs_pkg::WINDOW_START_RST;
			window_count_q <= ncs_pkg::WINDOW_COUNT_RST;
			issue_cnt_q <= '0;
			have_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					ncs_pkg::CFG_WINDOW_START: window_start_q <= cfg_data[IW-1:0];
					ncs_pkg::CFG_WINDOW_COUNT: window_count_q <= cfg_data;
					default: ;
				endcase
			end
			// A search starts with an empty best and the full window still to read.
			if (state_q == ncs_pkg::ST_MOD && mod_done) begin
				issue_cnt_q <= (item_q.action == ncs_pkg::ACT_SEARCH) ? window_count_q : '0;
				have_q <= 1'b0;
			end else begin
				if (rd_en) begin
					issue_cnt_q <= issue_cnt_q - 1'b1;
				end
				if (dist_resp.valid) begin
					have_q <= 1'b1;
				end
			end
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (state_q == ncs_pkg::ST_MOD && mod_done) begin
			pos_q <= mod_rem[AW-1:0];
			best_q <= '0;
		end else begin
			if (rd_en) begin
				pos_q <= (pos_q == AW'(PALETTE_SIZE - 1)) ? '0 : pos_q + 1'b1;
			end
			// Only a strictly smaller distance replaces the best, so the first minimum stays.
			if (dist_resp.valid && (!have_q || dist_resp.sq_dist < best_d_q)) begin
				best_q <= dist_resp.idx;
				best_d_q <= dist_resp.sq_dist;
			end
		end
		if (load_result) begin
			result_q.is_search_answer <= (item_q.action == ncs_pkg::ACT_SEARCH);
			result_q.nearest_index <= (item_q.action == ncs_pkg::ACT_SEARCH) ? best_q : '0;
		end
	end

	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef SYNTH
	// Palette reads and distances belong to a running scan only.
	a_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pal_rd.valid || dist_resp.valid) |-> state_q == ncs_pkg::ST_SCAN)
		else $error("palette read or distance outside a scan");

	// A new result never overwrites one that is still held by a stalled receiver.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_result |-> !(result_valid_q && result_stall))
		else $error("result register overwritten while stalled");

	// An accepted item always goes to the index reduction first.
	a_accept_to_mod: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ncs_pkg::ST_MOD)
		else $error("accepted item did not start the index reduction");

	// The best index always lies inside the palette.
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> best_q <= IW'(PALETTE_SIZE - 1))
		else $error("best index beyond the palette");

	// A palette write happens only for a write item.
	a_write_kind: assert property (@(posedge clk) disable iff (!arst_n)
		pal_we |-> item_q.action == ncs_pkg::ACT_WRITE && state_q == ncs_pkg::ST_MOD)
		else $error("palette written outside a write item");
`endif

endmodule

`default_nettype wire

// ===== sv/ncs_mod.sv =====
// Reduction of an 8-bit index modulo the palette size by reciprocal multiplication, in two steps.
// Depends on ncs_pkg for the index width.
`default_nettype none

module ncs_mod #(
	parameter int PALETTE_SIZE = ncs_pkg::PALETTE_SIZE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [ncs_pkg::IDX_W-1:0] value,
	output logic done,
	output logic [ncs_pkg::IDX_W-1:0] remainder
);

	localparam int IW = ncs_pkg::IDX_W;
	localparam int SH = IW + $clog2(PALETTE_SIZE);
	localparam int MW = IW + 2;
	localparam int PW = IW + MW;
	// Reciprocal of the palette size scaled by 2^SH and rounded up. With this scale the top
	// bits of the product are the exact quotient of every IW-bit value.
	localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + PALETTE_SIZE - 1) / PALETTE_SIZE);
	localparam logic [PW-1:0] DIVISOR = PW'(PALETTE_SIZE);

	logic busy_q;
	logic done_q;
	logic [IW-1:0] val_q;
	logic [IW-1:0] quo_q;
	logic [IW-1:0] rem_q;
	logic [PW-1:0] prod;
	logic [PW-1:0] back;

	assign prod = PW'(value) * PW'(RECIP);
	assign back = PW'(quo_q) * DIVISOR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	// First step keeps the value and its quotient, the second subtracts quotient times size.
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			quo_q <= IW'(prod >> SH);
		end
		if (busy_q) begin
			rem_q <= val_q - back[IW-1:0];
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== sv/ncs_palette.sv =====
// Palette store: one write and one registered read port, with per-entry valid bits so that
// an entry never written reads as the default table. Depends on ncs_pkg.
`default_nettype none

module ncs_palette #(
	parameter int PALETTE_SIZE = ncs_pkg::PALETTE_SIZE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic we,
	input wire logic [$clog2(PALETTE_SIZE)-1:0] waddr,
	input wire logic [ncs_pkg::ENTRY_W-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(PALETTE_SIZE)-1:0] raddr,
	output ncs_pkg::pal_rd_t rd
);

	localparam int AW = $clog2(PALETTE_SIZE);

	logic [ncs_pkg::ENTRY_W-1:0] mem [PALETTE_SIZE];
	logic [PALETTE_SIZE-1:0] written_q;
	logic [ncs_pkg::ENTRY_W-1:0] rdata_s1;
	logic rwritten_s1;
	logic rvalid_s1;
	logic [AW-1:0] raddr_s1;
	logic [ncs_pkg::IDX_W-1:0] raddr_ext;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
			raddr_s1 <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rvalid_s1 <= 1'b0;
			rwritten_s1 <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			rvalid_s1 <= re;
			if (re) begin
				rwritten_s1 <= written_q[raddr];
			end
		end
	end

	assign raddr_ext = ncs_pkg::IDX_W'(raddr_s1);

	always_comb begin
		rd.valid = rvalid_s1;
		rd.addr = raddr_ext;
		rd.entry = rwritten_s1 ? rdata_s1 : ncs_pkg::DEFAULT_PALETTE[raddr_ext];
	end

endmodule

`default_nettype wire

// ===== sv/ncs_dist.sv =====
// Distance unit: squared Euclidean distance between a pixel and one palette entry, registered.
// Depends on ncs_pkg for widths and the read and result structs.
`default_nettype none

module ncs_dist (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [ncs_pkg::CH_W-1:0] pixel_red,
	input wire logic [ncs_pkg::CH_W-1:0] pixel_green,
	input wire logic [ncs_pkg::CH_W-1:0] pixel_blue,
	input wire ncs_pkg::pal_rd_t rd,
	output ncs_pkg::dist_resp_t resp
);

	localparam int NW = ncs_pkg::NIB_W;

	// A stored nibble n stands for the 8-bit level n*16.
	function automatic logic [ncs_pkg::SQ_W-1:0] channel_sq(
		input logic [ncs_pkg::CH_W-1:0] pix,
		input logic [NW-1:0] nib
	);
		logic [ncs_pkg::CH_W-1:0] lvl;
		logic [ncs_pkg::CH_W-1:0] diff;
		lvl = {nib, {NW{1'b0}}};
		diff = (pix > lvl) ? (pix - lvl) : (lvl - pix);
		return diff * diff;
	endfunction

	logic [ncs_pkg::DIST_W-1:0] sq_sum;
	logic valid_s2;
	logic [ncs_pkg::IDX_W-1:0] idx_s2;
	logic [ncs_pkg::DIST_W-1:0] dist_s2;

	assign sq_sum = ncs_pkg::DIST_W'(channel_sq(pixel_red, rd.entry[3*NW-1:2*NW]))
		+ ncs_pkg::DIST_W'(channel_sq(pixel_green, rd.entry[2*NW-1:NW]))
		+ ncs_pkg::DIST_W'(channel_sq(pixel_blue, rd.entry[NW-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= rd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.valid) begin
			idx_s2 <= rd.addr;
			dist_s2 <= sq_sum;
		end
	end

	always_comb begin
		resp.valid = valid_s2;
		resp.idx = idx_s2;
		resp.sq_dist = dist_s2;
	end

endmodule

`default_nettype wire

// ===== bench/nearest_palette_color_search_test.sv =====
// Self-checking testbench for nearest_palette_color_search: directed and random palette
// writes and nearest-color searches under several window settings, with random idling.
// Depends on ncs_pkg and the block's RTL only.
`default_nettype none

module nearest_palette_color_search_test;
	timeunit 1ns;
	timeprecision 1ps;

	// The palette size the block is built with; the predictor takes indexes modulo it.
	localparam int PAL_SIZE = ncs_pkg::PALETTE_SIZE_DEF;
	localparam int RANDOM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 65;
	localparam int ITEM_BITS = $bits(ncs_pkg::item_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_stall;
	ncs_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	ncs_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	ncs_pkg::cfg_reg_t cfg_index = ncs_pkg::CFG_WINDOW_START;
	logic [ncs_pkg::COUNT_W-1:0] cfg_data = '0;

	// Requests waiting for the driver, and responses the block still owes us.
	ncs_pkg::item_t queued_requests[$];
	ncs_pkg::result_t pending_responses[$];

	// Our own copy of the block's state: palette contents and the search window.
	logic [ncs_pkg::ENTRY_W-1:0] pal_model[ncs_pkg::TABLE_DEPTH];
	logic [ncs_pkg::IDX_W-1:0] win_first;
	logic [ncs_pkg::COUNT_W-1:0] win_len;

	// When set, neither side idles; one random phase runs this way end to end.
	bit quiet = 1'b0;

	int unsigned mismatches = 0;
	int unsigned writes_seen = 0;
	int unsigned searches_seen = 0;
	int unsigned windows_used = 1;

	nearest_palette_color_search #(
		.PALETTE_SIZE(PAL_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Squared difference between an 8-bit pixel channel and a stored nibble, where the
	// nibble n stands for the 8-bit level n*16.
	function automatic int unsigned level_sq_diff(logic [7:0] pix, logic [3:0] nib);
		int unsigned lvl;
		int unsigned p;
		lvl = 16 * nib;
		p = pix;
		return (p > lvl) ? (p - lvl) * (p - lvl) : (lvl - p) * (lvl - p);
	endfunction

	// Works out the block's response to one accepted request and applies any palette
	// write to our copy. A search walks the window in order, wrapping at the end of the
	// palette, and only a strictly smaller distance replaces the current best, so ties
	// and revisits in an over-long window keep the earliest entry met. An empty window
	// never sets a best and answers index zero.
	function automatic ncs_pkg::result_t palette_response(ncs_pkg::item_t req);
		ncs_pkg::result_t rsp;
		int unsigned pos;
		int unsigned cand_dist;
		int unsigned best_dist;
		logic [ncs_pkg::ENTRY_W-1:0] e;
		bit found;
		rsp = '0;
		if (req.action == ncs_pkg::ACT_WRITE) begin
			pal_model[req.entry_index % PAL_SIZE] =
				{req.entry_red[7:4], req.entry_green[7:4], req.entry_blue[7:4]};
		end else begin
			found = 1'b0;
			best_dist = 0;
			pos = win_first % PAL_SIZE;
			for (int unsigned n = 0; n < win_len; n++) begin
				e = pal_model[pos];
				cand_dist = level_sq_diff(req.pixel_red, e[11:8])
					+ level_sq_diff(req.pixel_green, e[7:4])
					+ level_sq_diff(req.pixel_blue, e[3:0]);
				if (!found || cand_dist < best_dist) begin
					found = 1'b1;
					best_dist = cand_dist;
					rsp.nearest_index = pos[ncs_pkg::IDX_W-1:0];
				end
				pos = (pos + 1) % PAL_SIZE;
			end
			rsp.is_search_answer = 1'b1;
		end
		return rsp;
	endfunction

	// Request builders. The fields that the action ignores carry random values so that
	// the block is seen to ignore them.
	function automatic ncs_pkg::item_t search_req(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		ncs_pkg::item_t req;
		req = ITEM_BITS'({$urandom, $urandom});
		req.action = ncs_pkg::ACT_SEARCH;
		req.pixel_red = r;
		req.pixel_green = g;
		req.pixel_blue = b;
		return req;
	endfunction

	function automatic ncs_pkg::item_t write_req(logic [7:0] idx, logic [7:0] r,
			logic [7:0] g, logic [7:0] b);
		ncs_pkg::item_t req;
		req = ITEM_BITS'({$urandom, $urandom});
		req.action = ncs_pkg::ACT_WRITE;
		req.entry_index = idx;
		req.entry_red = r;
		req.entry_green = g;
		req.entry_blue = b;
		return req;
	endfunction

	// Appends one request to the driver's queue.
	function automatic void enqueue(ncs_pkg::item_t req);
		queued_requests = {queued_requests, req};
	endfunction

	// Driver: offers the next queued request, holds it steady while stalled, and idles
	// at random between transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || !item_stall) begin
			if (queued_requests.size() != 0 && (quiet || $urandom_range(99) >= 15)) begin
				item_valid <= 1'b1;
				item <= queued_requests.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result transfer against the oldest pending response, then
	// follows configuration writes and accepted requests in the predictor. The check
	// comes first so that a request accepted on this edge can never be matched by a
	// result seen on the same edge. It also drives the random stall on the result side.
	always @(posedge clk or negedge arst_n) begin : monitor
		ncs_pkg::result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			for (int k = 0; k < ncs_pkg::TABLE_DEPTH; k++)
				pal_model[k] = ncs_pkg::DEFAULT_PALETTE[k];
			win_first = ncs_pkg::WINDOW_START_RST;
			win_len = ncs_pkg::WINDOW_COUNT_RST;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_responses.size() == 0) begin
					$error("result transfer with nothing expected: nearest_index %0d, is_search_answer %0d",
						result.nearest_index, result.is_search_answer);
					mismatches++;
				end else begin
					want = pending_responses.pop_front();
					if (result.nearest_index !== want.nearest_index) begin
						$error("nearest_index: expected %0d, got %0d",
							want.nearest_index, result.nearest_index);
						mismatches++;
					end
					if (result.is_search_answer !== want.is_search_answer) begin
						$error("is_search_answer: expected %0d, got %0d",
							want.is_search_answer, result.is_search_answer);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ncs_pkg::CFG_WINDOW_START: begin
						win_first = cfg_data[ncs_pkg::IDX_W-1:0];
					end
					ncs_pkg::CFG_WINDOW_COUNT: begin
						win_len = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (item_valid && !item_stall) begin
				pending_responses = {pending_responses, palette_response(item)};
				if (item.action == ncs_pkg::ACT_WRITE)
					writes_seen++;
				else
					searches_seen++;
			end
			result_stall <= !quiet && ($urandom_range(99) < 15);
		end
	end

	// One register write on the configuration channel. The next call waits for a fresh
	// edge before raising valid, so valid never drops and rises in the same step.
	task automatic cfg_write(ncs_pkg::cfg_reg_t idx, logic [ncs_pkg::COUNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Moves the search window. Only called while the block is idle.
	task automatic set_window(logic [ncs_pkg::IDX_W-1:0] first,
			logic [ncs_pkg::COUNT_W-1:0] len);
		cfg_write(ncs_pkg::CFG_WINDOW_START, {1'b0, first});
		cfg_write(ncs_pkg::CFG_WINDOW_COUNT, len);
		windows_used++;
		@(negedge clk);
	endtask

	// Waits until every queued request has been transferred and answered. Every request
	// gives a result, so after that the block is idle; a short pause follows anyway.
	task automatic wait_drained();
		do @(negedge clk);
		while (queued_requests.size() != 0 || item_valid || pending_responses.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [ncs_pkg::COUNT_W-1:0] span;
		logic [ncs_pkg::ENTRY_W-1:0] near;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, first with the window left at its reset value: the whole palette.
		// Black ties between entries 0 and 16 of the default table, so the earlier wins.
		enqueue(search_req(8'h00, 8'h00, 8'h00));
		enqueue(search_req(8'hff, 8'hff, 8'hff));
		enqueue(search_req(8'h80, 8'h00, 8'h00));
		enqueue(search_req(8'haa, 8'hff, 8'hee));
		// Writes at both ends of the index range; the low nibbles must be dropped.
		enqueue(write_req(8'h00, 8'hff, 8'hff, 8'hff));
		enqueue(write_req(8'hff, 8'h0f, 8'h0f, 8'h0f));
		enqueue(search_req(8'h00, 8'h00, 8'h00));
		enqueue(search_req(8'hff, 8'hff, 8'hff));
		enqueue(write_req(8'h80, 8'h12, 8'h34, 8'h56));
		enqueue(search_req(8'h10, 8'h30, 8'h50));
		// Two more copies of the default grey at 24, one below it and one above it:
		// the lowest index must win.
		enqueue(write_req(8'h07, 8'h80, 8'h80, 8'h80));
		enqueue(write_req(8'hc8, 8'h80, 8'h80, 8'h80));
		enqueue(search_req(8'h88, 8'h88, 8'h88));
		wait_drained();

		// An empty window answers zero, whatever the start.
		set_window(8'd77, 9'd0);
		enqueue(search_req(8'h5a, 8'ha5, 8'h3c));
		enqueue(write_req(8'd77, 8'hf0, 8'h00, 8'hf0));
		enqueue(search_req(8'hf0, 8'h00, 8'hf0));
		wait_drained();

		// A single entry at the top of the index range.
		set_window(8'd255, 9'd1);
		enqueue(search_req(8'h00, 8'h00, 8'h00));
		enqueue(search_req(8'hff, 8'hff, 8'hff));
		wait_drained();

		// A window that runs past the last entry and wraps to the first.
		set_window(8'd250, 9'd20);
		enqueue(search_req(8'hff, 8'hff, 8'hff));
		enqueue(search_req(8'h00, 8'h00, 8'h00));
		wait_drained();

		// The longest window the register holds goes round the palette almost twice;
		// revisited entries must not displace the first minimum.
		set_window(8'd255, 9'd511);
		enqueue(search_req(8'h00, 8'h00, 8'h00));
		enqueue(search_req(8'hf0, 8'hf0, 8'hf0));
		wait_drained();

		// Random part. Each phase picks a window, mostly short ones to keep the run quick,
		// with full and over-long windows mixed in. Half the searches aim close to a
		// palette entry so that exact hits and ties come up often.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			quiet = (ph == 4);
			case ($urandom_range(9))
				0: begin
					span = 9'($urandom_range(2));
				end
				1, 2, 3, 4, 5: begin
					span = 9'($urandom_range(48, 1));
				end
				6, 7: begin
					span = 9'd256;
				end
				8: begin
					span = 9'($urandom_range(255, 200));
				end
				default: begin
					span = 9'($urandom_range(511, 257));
				end
			endcase
			set_window(8'($urandom_range(255)), span);
			repeat (ITEMS_PER_PHASE) begin
				if ($urandom_range(99) < 40) begin
					enqueue(write_req(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
				end else if ($urandom_range(1) == 0) begin
					enqueue(search_req(8'($urandom), 8'($urandom), 8'($urandom)));
				end else begin
					near = pal_model[$urandom_range(ncs_pkg::TABLE_DEPTH - 1)];
					enqueue(search_req({near[11:8], 4'($urandom_range(15))},
						{near[7:4], 4'($urandom_range(15))},
						{near[3:0], 4'($urandom_range(15))}));
				end
			end
			wait_drained();
		end
		quiet = 1'b0;

		repeat (20) @(negedge clk);
		$display("Checked %0d palette writes and %0d searches across %0d window settings.",
			writes_seen, searches_seen, windows_used);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches found.", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog, several times the slowest plausible run.
	initial begin
		#8ms;
		$display("Timeout with %0d requests queued and %0d responses outstanding.",
			queued_requests.size(), pending_responses.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
